>>> src/llb_pkg.sv
// llb_pkg: widths, codes and shared types of the landmark lower bound unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package llb_pkg;

  localparam int LANDMARKS = 16;
  localparam int VERTICES  = 1024;
  localparam int VTX_W     = $clog2(VERTICES);
  localparam int LM_W      = 4;
  localparam int DIST_W    = 31;
  localparam int MASK_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  localparam logic [DIST_W-1:0] UNREACHABLE = {DIST_W{1'b1}};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DESTINATION = 1'b0,
    REG_ACTIVE_MASK = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             valid;
    logic [VTX_W-1:0] vertex;
  } tok_t;

  typedef struct packed {
    logic [VTX_W-1:0]  vertex;
    logic [DIST_W-1:0] fwd;
    logic [DIST_W-1:0] rev;
  } wr_t;

endpackage

`default_nettype wire

>>> src/landmark_lower_bound_unit.sv
// landmark_lower_bound_unit: top level, channel control and the row of cells.
// Depends on llb_pkg and llb_cell.
//
//   channel | direction | handshake          | payload
//   in_     | input     | valid / stall      | operation, landmark, vertex, distances
//   out_    | output    | valid / stall      | bound
//   cfg_    | input     | valid / ready      | index, data
//
// A load writes its entry at its transfer edge. A query walks the row, one
// landmark cell per cycle; its result passes every cell's bound register and the
// done flag before it is registered at the output, the input stalls meanwhile.
// rst_n is synchronous; it clears control state and the configuration registers,
// the tables keep their contents. A waiting result stalls the input, loads
// included; transfers resume in the cycle it is taken.
`default_nettype none

module landmark_lower_bound_unit (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire                            in_operation,
  input  wire  [llb_pkg::LM_W-1:0]       in_landmark,
  input  wire  [llb_pkg::VTX_W-1:0]      in_vertex,
  input  wire  [llb_pkg::DIST_W-1:0]     in_forward_distance,
  input  wire  [llb_pkg::DIST_W-1:0]     in_reverse_distance,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [llb_pkg::DIST_W-1:0]     out_bound,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [llb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [llb_pkg::CFG_W-1:0]      cfg_data
);
  import llb_pkg::*;

  logic [VTX_W-1:0]  dest_r;
  logic [MASK_W-1:0] mask_r;
  logic              busy_r;
  logic              done_r;
  logic              out_valid_r;
  logic [DIST_W-1:0] out_bound_r;

  logic              in_xfer, is_query;
  tok_t              head_tok;
  wr_t               wr;
  tok_t              tok_in  [LANDMARKS];
  tok_t              tok_out [LANDMARKS];
  logic [DIST_W-1:0] best_in  [LANDMARKS];
  logic [DIST_W-1:0] best_out [LANDMARKS];
  logic [LANDMARKS-1:0] wr_en;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy_r || (out_valid_r && out_stall);
  assign in_xfer   = in_valid && !in_stall;
  assign is_query  = (op_t'(in_operation) == OP_QUERY);

  assign head_tok = '{valid: in_xfer && is_query, vertex: in_vertex};
  assign wr       = '{vertex: in_vertex, fwd: in_forward_distance,
                      rev: in_reverse_distance};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r <= '0;
      mask_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DESTINATION: dest_r <= cfg_data[VTX_W-1:0];
        REG_ACTIVE_MASK: mask_r <= cfg_data[MASK_W-1:0];
        default:         dest_r <= dest_r;
      endcase
    end
  end

  genvar l;
  generate
    for (l = 0; l < LANDMARKS; l++) begin : g_cell
      if (l == 0) begin : g_head
        assign tok_in[l]  = head_tok;
        assign best_in[l] = '0;
      end else begin : g_link
        assign tok_in[l]  = tok_out[l-1];
        assign best_in[l] = best_out[l-1];
      end

      assign wr_en[l] = in_xfer && !is_query && (in_landmark == LM_W'(l));

      llb_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en[l]),
        .wr       (wr),
        .dest     (dest_r),
        .act      (mask_r[l]),
        .tok_in   (tok_in[l]),
        .tok_out  (tok_out[l]),
        .best_in  (best_in[l]),
        .best_out (best_out[l])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      done_r <= tok_out[LANDMARKS-1].valid;
      if (head_tok.valid) begin
        busy_r <= 1'b1;
      end else if (done_r) begin
        busy_r <= 1'b0;
      end
      if (done_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_r) begin
      out_bound_r <= best_out[LANDMARKS-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_bound = out_bound_r;

endmodule

`default_nettype wire

>>> src/llb_cell.sv
// llb_cell: one landmark's forward and reverse tables plus its bound stage.
// Passes the query token on each cycle and folds its bound into the running max.
// Depends on llb_pkg.
`default_nettype none

module llb_cell (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         wr_en,
  input  wire  llb_pkg::wr_t          wr,
  input  wire  [llb_pkg::VTX_W-1:0]   dest,
  input  wire                         act,
  input  wire  llb_pkg::tok_t         tok_in,
  output llb_pkg::tok_t               tok_out,
  input  wire  [llb_pkg::DIST_W-1:0]  best_in,
  output logic [llb_pkg::DIST_W-1:0]  best_out
);
  import llb_pkg::*;

  logic [DIST_W-1:0] fwd_mem [VERTICES];
  logic [DIST_W-1:0] rev_mem [VERTICES];

  logic [DIST_W-1:0] fd_r, fv_r, rv_r, rd_r;
  tok_t              tok_r;
  logic [DIST_W-1:0] best_r, best_nxt;

  logic              have_f, have_r, have;
  logic signed [DIST_W:0] tf, tr, lower;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_mem[wr.vertex] <= wr.fwd;
      rev_mem[wr.vertex] <= wr.rev;
    end
    fd_r <= fwd_mem[dest];
    fv_r <= fwd_mem[tok_in.vertex];
    rv_r <= rev_mem[tok_in.vertex];
    rd_r <= rev_mem[dest];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
    end
  end

  // data of this cell and best of the previous cell arrive in the same cycle
  always_comb begin
    have_f = (fd_r != UNREACHABLE) && (fv_r != UNREACHABLE);
    have_r = (rv_r != UNREACHABLE) && (rd_r != UNREACHABLE);
    tf     = $signed({1'b0, fd_r}) - $signed({1'b0, fv_r});
    tr     = $signed({1'b0, rv_r}) - $signed({1'b0, rd_r});
    have   = act && (have_f || have_r);
    if (have_f && have_r) begin
      lower = (tr > tf) ? tr : tf;
    end else if (have_r) begin
      lower = tr;
    end else begin
      lower = tf;
    end
    if (have && (lower > $signed({1'b0, best_in}))) begin
      best_nxt = lower[DIST_W-1:0];
    end else begin
      best_nxt = best_in;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

  assign tok_out  = tok_r;
  assign best_out = best_r;

endmodule

`default_nettype wire

>>> src/llb_checker.sv
// llb_checker: port-level checks of landmark_lower_bound_unit, bound to it below.
// Depends on llb_pkg.
`default_nettype none

module llb_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_stall,
  input wire                          in_operation,
  input wire                          out_valid,
  input wire                          out_stall,
  input wire [llb_pkg::DIST_W-1:0]    out_bound
);
  import llb_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bound))
    else $error("stalled result dropped or changed");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (op_t'(in_operation) == OP_LOAD) && !out_valid |=> !out_valid)
    else $error("result appeared after a load transfer");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (op_t'(in_operation) == OP_QUERY) |=> in_stall && !out_valid)
    else $error("query did not hold off the input or left a stale result");

  a_bound_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bound != UNREACHABLE))
    else $error("bound carries the unreachable marker");

endmodule

bind landmark_lower_bound_unit llb_checker u_llb_checker (.*);

`default_nettype wire
